// ----- rtl/pel_pkg.sv -----
// Shared types, register indexes and defaults for the keypad PIN lock.
`default_nettype none

package pel_pkg;

  localparam int MAX_DIGITS_DEF = 6;

  localparam int DIGIT_W    = 4;
  localparam int PIN_W      = 24;
  localparam int LEN_W      = 3;
  localparam int TICKS_W    = 16;
  localparam int COUNT_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [PIN_W-1:0]   PIN_CODE_RST      = 24'h004321;
  localparam logic [LEN_W-1:0]   PIN_LENGTH_RST    = 3'd4;
  localparam logic [TICKS_W-1:0] MESSAGE_TICKS_RST = 16'd120;

  localparam logic [CFG_IDX_W-1:0] CFG_PIN_CODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_TICKS = 2'd2;

  typedef enum logic [1:0] {
    CMD_DIGIT  = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SUBMIT = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    VERDICT_NONE    = 2'd0,
    VERDICT_GRANTED = 2'd1,
    VERDICT_DENIED  = 2'd2
  } verdict_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [DIGIT_W-1:0] digit;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] entered_count;
    verdict_t           verdict;
    logic               message_active;
    logic               digit_ignored;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/pel_in_reg.sv -----
// Input register stage: holds one accepted keypad word until the core takes it.
`default_nettype none

module pel_in_reg
  import pel_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       stage_valid,
  input  wire logic  stage_ready,
  output item_t      stage_item
);

  logic  valid_r;
  item_t item_r;

  // take a new word when empty or when the held word moves on this cycle
  assign in_ready    = !valid_r || stage_ready;
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pel_core.sv -----
// Lock state, configuration registers, command decode and result register.
`default_nettype none

module pel_core
  import pel_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire item_t                 item,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output result_t                    res
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [PIN_W-1:0]   pin_code_r;
  logic [LEN_W-1:0]   pin_length_r;
  logic [TICKS_W-1:0] message_ticks_r;

  logic [DIGIT_W-1:0] digits_r [MAX_DIGITS];
  logic [CNT_W-1:0]   count_r, count_nxt;
  verdict_t           verdict_r, verdict_nxt;
  logic [TICKS_W-1:0] timer_r, timer_nxt;

  logic               res_valid_r;
  result_t            res_r;

  logic               advance;
  logic               mismatch;
  logic               match;
  logic [CNT_W-1:0]   base_count;
  logic               full;
  logic               ignored;
  logic               write_digit;
  logic [TICKS_W-1:0] timer_dec;

  assign item_ready = !res_valid_r || res_ready;
  assign advance    = item_valid && item_ready;
  assign res_valid  = res_valid_r;
  assign res        = res_r;

  // compare only the digits that are entered
  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (CNT_W'(i) < count_r && digits_r[i] != pin_code_r[DIGIT_W*i +: DIGIT_W]) begin
        mismatch = 1'b1;
      end
    end
    match = !mismatch && (LEN_W'(count_r) == pin_length_r);
  end

  // a digit press wipes a showing verdict before it appends
  assign base_count = (verdict_r != VERDICT_NONE) ? '0 : count_r;
  assign full       = base_count >= CNT_W'(MAX_DIGITS);
  assign timer_dec  = timer_r - TICKS_W'(1);

  always_comb begin
    count_nxt   = count_r;
    verdict_nxt = verdict_r;
    timer_nxt   = timer_r;
    ignored     = 1'b0;
    write_digit = 1'b0;
    unique case (item.cmd)
      CMD_DIGIT: begin
        if (verdict_r != VERDICT_NONE) begin
          verdict_nxt = VERDICT_NONE;
          timer_nxt   = '0;
        end
        if (full) begin
          ignored   = 1'b1;
          count_nxt = base_count;
        end else begin
          write_digit = 1'b1;
          count_nxt   = base_count + CNT_W'(1);
        end
      end
      CMD_CLEAR: begin
        count_nxt   = '0;
        verdict_nxt = VERDICT_NONE;
        timer_nxt   = '0;
      end
      CMD_SUBMIT: begin
        if (count_r != '0) begin
          verdict_nxt = match ? VERDICT_GRANTED : VERDICT_DENIED;
          timer_nxt   = message_ticks_r;
        end
      end
      CMD_TICK: begin
        if (timer_r != '0) begin
          timer_nxt = timer_dec;
          if (timer_dec == '0 && verdict_r != VERDICT_NONE) begin
            count_nxt   = '0;
            verdict_nxt = VERDICT_NONE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_code_r      <= PIN_CODE_RST;
      pin_length_r    <= PIN_LENGTH_RST;
      message_ticks_r <= MESSAGE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIN_CODE:      pin_code_r      <= cfg_wdata[PIN_W-1:0];
        CFG_PIN_LENGTH:    pin_length_r    <= cfg_wdata[LEN_W-1:0];
        CFG_MESSAGE_TICKS: message_ticks_r <= cfg_wdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      verdict_r <= VERDICT_NONE;
      timer_r   <= '0;
    end else if (advance) begin
      count_r   <= count_nxt;
      verdict_r <= verdict_nxt;
      timer_r   <= timer_nxt;
    end
  end

  // digits past the count are never compared, so they need no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (advance && write_digit && base_count == CNT_W'(i)) begin
        digits_r[i] <= item.digit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (item_ready) begin
      res_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r.entered_count  <= COUNT_W'(count_nxt);
      res_r.verdict        <= verdict_nxt;
      res_r.message_active <= timer_nxt != '0;
      res_r.digit_ignored  <= ignored;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pin_entry_lock.sv -----
// Path: in_* passes the input register, then the result register, to out_*.
// Throughput: one word per cycle unless out_tready stalls; the input register and
// result register let a new word in while a finished result waits for out_tready.
// Reset: synchronous, active low; clears the entry, verdict and timer and
// loads the default PIN 1234, length 4 and a 120-tick message time.
`default_nettype none

module pin_entry_lock
  import pel_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // digit[3:0], zero pad
  input  wire logic [1:0]            in_tuser,   // cmd[1:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata   // entered_count[2:0], verdict[4:3],
                                                 // message_active[5], digit_ignored[6]
);

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    stage_ready;
  result_t res;

  assign in_item.cmd   = cmd_t'(in_tuser);
  assign in_item.digit = in_tdata[DIGIT_W-1:0];

  pel_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_item     (in_item),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage_item  (stage_item)
  );

  pel_core #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (stage_valid),
    .item_ready (stage_ready),
    .item       (stage_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {1'b0, res.digit_ignored, res.message_active, res.verdict,
                      res.entered_count};

endmodule

`default_nettype wire

// ----- rtl/pel_checker.sv -----
// Port-level checks on the result stream of the PIN lock, bound to the top level.
`default_nettype none

module pel_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:3] != 2'd3)
    else $error("verdict code out of range");

  // the timer only runs while a verdict shows
  a_msg_needs_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[4:3] != 2'd0)
    else $error("message active without a verdict");

  // a dropped digit means a full entry and no verdict
  a_ignored_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> out_tdata[2:0] != 3'd0 && out_tdata[4:3] == 2'd0)
    else $error("digit dropped with empty entry or verdict showing");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7])
    else $error("pad bit set");

endmodule

bind pin_entry_lock pel_checker u_pel_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- test/pin_entry_lock_tb.sv -----
// Self-checking testbench for the keypad PIN lock: directed keys, random entry attempts.
`timescale 1ns / 1ps

module pin_entry_lock_tb;
  import pel_pkg::*;

  // Shadow copy of the lock: registers, entry state and the status words still owed.
  class lock_shadow;
    logic [PIN_W-1:0]   pin_code;
    logic [LEN_W-1:0]   pin_len;
    logic [TICKS_W-1:0] msg_ticks;
    logic [DIGIT_W-1:0] digits[MAX_DIGITS_DEF];
    logic [COUNT_W-1:0] count;
    verdict_t           verdict;
    logic [TICKS_W-1:0] timer;
    result_t            pending_status[$];
    int unsigned        errors, checked, n_granted, n_denied, n_dropped, n_expired;

    function new();
      pin_code  = PIN_CODE_RST;
      pin_len   = PIN_LENGTH_RST;
      msg_ticks = MESSAGE_TICKS_RST;
      wipe();
    endfunction

    function void wipe();
      foreach (digits[i]) digits[i] = '0;
      count   = '0;
      verdict = VERDICT_NONE;
      timer   = '0;
    endfunction

    function bit pin_matches();
      if (count != pin_len) return 0;
      for (int i = 0; i < count; i++) begin
        if (digits[i] != pin_code[4*i +: 4]) return 0;
      end
      return 1;
    endfunction

    // Note one accepted key word and queue the status it must produce.
    function void apply_word(cmd_t c, logic [DIGIT_W-1:0] d);
      result_t r;
      logic    dropped;
      dropped = 1'b0;
      case (c)
        CMD_DIGIT: begin
          if (verdict != VERDICT_NONE) wipe();
          if (count >= MAX_DIGITS_DEF) begin
            dropped = 1'b1;
            n_dropped++;
          end else begin
            digits[count] = d;
            count++;
          end
        end
        CMD_CLEAR: wipe();
        CMD_SUBMIT: begin
          if (count != 0) begin
            verdict = pin_matches() ? VERDICT_GRANTED : VERDICT_DENIED;
            if (verdict == VERDICT_GRANTED) n_granted++;
            else n_denied++;
            timer = msg_ticks;
          end
        end
        default: begin
          if (timer != 0) begin
            timer--;
            if (timer == 0 && verdict != VERDICT_NONE) begin
              wipe();
              n_expired++;
            end
          end
        end
      endcase
      r.entered_count  = count;
      r.verdict        = verdict;
      r.message_active = (timer != 0);
      r.digit_ignored  = dropped;
      pending_status.push_back(r);
    endfunction

    function void check_status(logic [7:0] w);
      result_t want, got;
      got.entered_count  = w[2:0];
      got.verdict        = verdict_t'(w[4:3]);
      got.message_active = w[5];
      got.digit_ignored  = w[6];
      checked++;
      if (pending_status.size() == 0) begin
        errors++;
        if (errors <= 10) $display("mismatch: status word 0x%02h with nothing pending", w);
        return;
      end
      want = pending_status.pop_front();
      if (got.entered_count !== want.entered_count || got.verdict !== want.verdict ||
          got.message_active !== want.message_active ||
          got.digit_ignored !== want.digit_ignored) begin
        errors++;
        if (errors <= 10) begin
          $display(
            "mismatch %0d exp/act: cnt %0d/%0d verdict %0d/%0d active %0b/%0b drop %0b/%0b",
            checked, want.entered_count, got.entered_count, want.verdict, got.verdict,
            want.message_active, got.message_active, want.digit_ignored,
            got.digit_ignored);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // digit[3:0], zero pad
  logic [1:0]            in_tuser;   // cmd[1:0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;  // entered_count[2:0], verdict[4:3], message_active[5],
                                     // digit_ignored[6], zero pad

  lock_shadow  shadow = new();
  int unsigned sent;
  int unsigned n_settings;
  int unsigned idle_cycles;
  int unsigned key_burst;
  int unsigned sink_burst;
  bit          hold_request;

  pin_entry_lock dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.check_status(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 3000) begin
      $display("FAIL pin_entry_lock");
      $finish;
    end
  end

  // Status sink: random stalls per word, bursts with none, one long hold on request.
  initial begin : result_sink
    int unsigned gap;
    out_tready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (hold_request) begin
          gap = 60;
          hold_request = 1'b0;
        end else if (sink_burst != 0) begin
          gap = 0;
          sink_burst--;
        end else begin
          if ($urandom_range(0, 15) == 0) sink_burst = 24;
          gap = $urandom_range(0, 8);
        end
        if (gap != 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  // Offer one key word after a random gap; return at the edge that takes it.
  task automatic send_key(cmd_t c, logic [DIGIT_W-1:0] d);
    int unsigned gap;
    if (key_burst != 0) begin
      gap = 0;
      key_burst--;
    end else begin
      if ($urandom_range(0, 15) == 0) key_burst = 20;
      gap = $urandom_range(0, 8);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {4'b0, d};
    do @(posedge clk); while (!in_tready);
    shadow.apply_word(c, d);
    sent++;
  endtask

  // Drop valid and hold until every status word is back.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (shadow.pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(logic [PIN_W-1:0] code, logic [LEN_W-1:0] len,
                               logic [TICKS_W-1:0] ticks);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PIN_CODE;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_index <= CFG_PIN_LENGTH;
    cfg_wdata <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_index <= CFG_MESSAGE_TICKS;
    cfg_wdata <= CFG_DATA_W'(ticks);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.pin_code  = code;
    shadow.pin_len   = len;
    shadow.msg_ticks = ticks;
    n_settings++;
  endtask

  // Key in the PIN, sometimes wrong, short or long, then submit and let ticks run.
  task automatic enter_attempt();
    int unsigned len, bad_at, n_ticks, cap, i;
    logic [DIGIT_W-1:0] nib;
    if (shadow.pin_len >= 1 && shadow.pin_len <= MAX_DIGITS_DEF) len = shadow.pin_len;
    else len = $urandom_range(1, MAX_DIGITS_DEF);
    case ($urandom_range(0, 7))
      0: len = len + 1;
      1: if (len > 1) len = len - 1;
      default: ;
    endcase
    bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : 99;
    if ($urandom_range(0, 3) == 0) send_key(CMD_CLEAR, 4'($urandom_range(0, 15)));
    for (i = 0; i < len; i++) begin
      if (i < MAX_DIGITS_DEF) nib = shadow.pin_code[4*i +: 4];
      else nib = 4'($urandom_range(0, 15));
      if (i == bad_at) nib = nib ^ 4'($urandom_range(1, 15));
      send_key(CMD_DIGIT, nib);
    end
    send_key(CMD_SUBMIT, 4'($urandom_range(0, 15)));
    if ($urandom_range(0, 5) == 0) send_key(CMD_SUBMIT, 4'($urandom_range(0, 15)));
    cap = (shadow.msg_ticks < 8) ? shadow.msg_ticks : 8;
    n_ticks = $urandom_range(0, cap + 1);
    repeat (n_ticks) send_key(CMD_TICK, 4'($urandom_range(0, 15)));
  endtask

  task automatic run_random(int unsigned words, bit with_hold);
    int unsigned first;
    bit          held;
    first = sent;
    held  = 1'b0;
    while (sent - first < words) begin
      if (with_hold && !held && sent - first >= 20) begin
        hold_request = 1'b1;
        held = 1'b1;
      end
      if ($urandom_range(0, 9) < 6) enter_attempt();
      else send_key(cmd_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_DIGIT;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_PIN_CODE;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default PIN 1234: empty submit, idle tick, grant, resubmit, full entry, denials.
    send_key(CMD_SUBMIT, 4'd0);
    send_key(CMD_TICK, 4'd15);
    send_key(CMD_DIGIT, 4'd1);
    send_key(CMD_DIGIT, 4'd2);
    send_key(CMD_DIGIT, 4'd3);
    send_key(CMD_DIGIT, 4'd4);
    send_key(CMD_SUBMIT, 4'd0);
    send_key(CMD_SUBMIT, 4'd9);
    send_key(CMD_TICK, 4'd0);
    send_key(CMD_DIGIT, 4'd5);
    send_key(CMD_CLEAR, 4'd15);
    send_key(CMD_DIGIT, 4'd9);
    send_key(CMD_DIGIT, 4'd0);
    send_key(CMD_DIGIT, 4'd15);
    send_key(CMD_DIGIT, 4'd10);
    send_key(CMD_DIGIT, 4'd1);
    send_key(CMD_DIGIT, 4'd2);
    send_key(CMD_DIGIT, 4'd3);
    send_key(CMD_SUBMIT, 4'd0);
    send_key(CMD_CLEAR, 4'd0);
    send_key(CMD_DIGIT, 4'd1);
    send_key(CMD_DIGIT, 4'd2);
    send_key(CMD_DIGIT, 4'd3);
    send_key(CMD_SUBMIT, 4'd0);
    send_key(CMD_TICK, 4'd0);
    settle();
    run_random(70, 1'b0);
    settle();

    load_settings(24'hFFFFFF, 3'd6, 16'd1);
    run_random(70, 1'b1);
    settle();
    load_settings(24'h000000, 3'd1, 16'hFFFF);
    run_random(70, 1'b0);
    settle();
    // Zero length never matches; zero ticks leave the verdict up until a key clears it.
    load_settings(PIN_W'($urandom_range(0, 24'hFFFFFF)), 3'd0, 16'd0);
    run_random(70, 1'b0);
    settle();
    load_settings(PIN_W'($urandom_range(0, 24'hFFFFFF)), 3'd7, 16'd3);
    run_random(70, 1'b0);
    settle();
    load_settings(PIN_W'($urandom_range(0, 24'hFFFFFF)), LEN_W'($urandom_range(1, 6)),
                  TICKS_W'($urandom_range(1, 8)));
    run_random(70, 1'b0);
    settle();
    repeat (8) @(posedge clk);

    $display("covered %0d key words under %0d register settings besides reset defaults",
             sent, n_settings);
    $display("%0d granted, %0d denied, %0d dropped digits, %0d verdicts timed out, %0d errors",
             shadow.n_granted, shadow.n_denied, shadow.n_dropped, shadow.n_expired,
             shadow.errors);
    if (shadow.errors == 0 && shadow.pending_status.size() == 0) begin
      $display("PASS pin_entry_lock");
    end else begin
      $display("FAIL pin_entry_lock");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pel_pkg.sv
rtl/pel_in_reg.sv
rtl/pel_core.sv
rtl/pin_entry_lock.sv
rtl/pel_checker.sv
test/pin_entry_lock_tb.sv
